// ===== design/sentence_word_order_reverser_defines.svh =====
// ----------------------------------------------------------------------------
// sentence word order reverser assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef SENTENCE_WORD_ORDER_REVERSER_DEFINES_SVH
`define SENTENCE_WORD_ORDER_REVERSER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SWR_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swr check failed");

// next-cycle implication, disabled while in reset
`define SWR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swr check failed");

`endif

// ===== design/swr_pkg.sv =====
// ----------------------------------------------------------------------------
// swr_pkg
// types and constants of the sentence word order reverser
// ----------------------------------------------------------------------------
package swr_pkg;

  localparam int MAX_LEN_DEF = 4096;

  localparam logic [7:0] SPACE_BYTE = 8'h20;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_PULL = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } res_item_t;

endpackage

// ===== design/swr_ram.sv =====
// ----------------------------------------------------------------------------
// swr_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
module swr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/sentence_word_order_reverser.sv =====
// ----------------------------------------------------------------------------
// sentence_word_order_reverser
// stores a sentence byte by byte, then returns it one byte per pull with the
// word order reversed; each space is its own token
// ----------------------------------------------------------------------------
// channel   ports                          beat
// input     in_valid / in_stall / in_item  push byte (kind 0) or pull (kind 1)
// result    res_valid / res_stall / res_item  one reordered byte per pull
//
// a push is taken in the idle state; a pull inside a word reads the ram, then
// delivers the byte. the first byte of a word first checks the last byte of
// the region, then scans backward over the other bytes of the word and the
// space before it, if any; all paced by the one registered ram read port. a
// space is delivered after its check; an empty or exhausted pull needs no read
// reset clears the sequencer, the counters and res_valid; the store is not cleared
// a stalled result holds in the output register; a finished pull then parks
// in a delivery state until the output register frees
// ----------------------------------------------------------------------------
`include "sentence_word_order_reverser_defines.svh"

module sentence_word_order_reverser #(
  parameter int MAX_LEN = swr_pkg::MAX_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  swr_pkg::in_item_t   in_item,
  output logic                res_valid,
  input  logic                res_stall,
  output swr_pkg::res_item_t  res_item
);

  import swr_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CHK  = 5'b00010,
    S_SCAN = 5'b00100,
    S_EMIT = 5'b01000,
    S_DLV  = 5'b10000
  } state_t;

  state_t          state, state_next;
  logic [LW-1:0]   stored_length, stored_length_next;
  logic [LW-1:0]   region_end, region_end_next;
  logic [LW-1:0]   word_cursor, word_cursor_next;
  logic [LW-1:0]   word_stop, word_stop_next;
  logic            emitting_word, emitting_word_next;
  logic            output_phase, output_phase_next;
  res_item_t       pend;

  logic            accept;
  logic            out_free;
  logic            res_load;
  logic            prod;
  res_item_t       prod_item;
  logic            start_word;
  logic [LW-1:0]   start_pos;
  logic [LW-1:0]   len_eff;
  logic [LW-1:0]   re_eff;
  logic            emit_eff;
  logic [LW-1:0]   cur_inc;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [AW-1:0]   rd_addr;
  logic [7:0]      rdata;

  swr_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_item.data_byte),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !res_valid || !res_stall;

  // a push after pulling restarts the sentence; a first pull latches the end
  assign len_eff  = output_phase ? '0 : stored_length;
  assign re_eff   = output_phase ? region_end : stored_length;
  assign emit_eff = output_phase && emitting_word;
  assign cur_inc  = word_cursor + LW'(1);

  assign ram_we    = accept && (in_item.kind == KIND_PUSH) && (len_eff < LW'(MAX_LEN));
  assign ram_waddr = len_eff[AW-1:0];

  always_comb begin
    state_next         = state;
    stored_length_next = stored_length;
    region_end_next    = region_end;
    word_cursor_next   = word_cursor;
    word_stop_next     = word_stop;
    emitting_word_next = emitting_word;
    output_phase_next  = output_phase;
    rd_addr            = '0;
    prod               = 1'b0;
    prod_item          = '0;
    start_word         = 1'b0;
    start_pos          = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_item.kind == KIND_PUSH) begin
            output_phase_next = 1'b0;
            if (output_phase) begin
              region_end_next    = '0;
              emitting_word_next = 1'b0;
            end
            stored_length_next = (len_eff < LW'(MAX_LEN)) ? len_eff + LW'(1) : len_eff;
          end else begin
            output_phase_next = 1'b1;
            if (!output_phase) begin
              region_end_next    = stored_length;
              emitting_word_next = 1'b0;
              word_cursor_next   = '0;
              word_stop_next     = '0;
            end
            if (emit_eff) begin
              rd_addr    = word_cursor[AW-1:0];
              state_next = S_EMIT;
            end else if (re_eff == '0) begin
              prod = 1'b1;
            end else begin
              rd_addr    = AW'(re_eff - LW'(1));
              state_next = S_CHK;
            end
          end
        end
      end
      S_CHK: begin
        if (rdata == SPACE_BYTE) begin
          region_end_next = region_end - LW'(1);
          prod            = 1'b1;
          prod_item       = '{out_byte: SPACE_BYTE, out_valid: 1'b1,
                              out_last: (region_end == LW'(1))};
        end else if (region_end == LW'(1)) begin
          start_word = 1'b1;
        end else begin
          word_cursor_next = region_end - LW'(1);
          rd_addr          = AW'(region_end - LW'(2));
          state_next       = S_SCAN;
        end
      end
      S_SCAN: begin
        // rdata holds the byte just before word_cursor
        if (rdata == SPACE_BYTE) begin
          start_word = 1'b1;
          start_pos  = word_cursor;
        end else if (word_cursor == LW'(1)) begin
          start_word = 1'b1;
        end else begin
          word_cursor_next = word_cursor - LW'(1);
          rd_addr          = AW'(word_cursor - LW'(2));
        end
      end
      S_EMIT: begin
        word_cursor_next   = cur_inc;
        emitting_word_next = (cur_inc < word_stop);
        prod               = 1'b1;
        prod_item          = '{out_byte: rdata, out_valid: 1'b1,
                               out_last: !(cur_inc < word_stop) && (region_end == '0)};
      end
      S_DLV: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (start_word) begin
      word_stop_next     = region_end;
      region_end_next    = start_pos;
      word_cursor_next   = start_pos;
      emitting_word_next = 1'b1;
      rd_addr            = start_pos[AW-1:0];
      state_next         = S_EMIT;
    end

    if (prod) begin
      state_next = out_free ? S_IDLE : S_DLV;
    end
  end

  assign res_load = (prod || (state == S_DLV)) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      stored_length <= '0;
      region_end    <= '0;
      word_cursor   <= '0;
      word_stop     <= '0;
      emitting_word <= 1'b0;
      output_phase  <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      stored_length <= stored_length_next;
      region_end    <= region_end_next;
      word_cursor   <= word_cursor_next;
      word_stop     <= word_stop_next;
      emitting_word <= emitting_word_next;
      output_phase  <= output_phase_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prod) begin
      pend <= prod_item;
    end
    if (res_load) begin
      res_item <= (state == S_DLV) ? pend : prod_item;
    end
  end

  `SWR_ASSERT_IMPL(a_emit_in_word, clk, rst, emitting_word && output_phase, word_cursor < word_stop)
  `SWR_ASSERT_IMPL(a_region_in_store, clk, rst, output_phase,
                   (region_end <= stored_length) && (word_stop <= stored_length))
  `SWR_ASSERT_IMPL(a_scan_range, clk, rst, state == S_SCAN,
                   (word_cursor != '0) && (word_cursor < region_end))
  `SWR_ASSERT_IMPL(a_empty_is_zero, clk, rst, res_valid && !res_item.out_valid,
                   (res_item.out_byte == 8'h00) && !res_item.out_last)

endmodule

// ===== bench/swr_reorder_checker.sv =====
// ----------------------------------------------------------------------------
// swr_reorder_checker
// watches both channels of the sentence word order reverser, keeps its own
// copy of the stored sentence and the reverse-scan state, and compares every
// result beat against the oldest predicted byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swr_reorder_checker #(
  parameter int MAX_LEN = swr_pkg::MAX_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  swr_pkg::in_item_t  in_item,
  input  logic               res_valid,
  input  logic               res_stall,
  input  swr_pkg::res_item_t res_item,
  output int                 fail_count,
  output int                 outstanding
);
  import swr_pkg::*;

  localparam int IW = $clog2(MAX_LEN + 1);

  // sized to the index width; only the first MAX_LEN entries are used
  logic [7:0]    sentence_mem [2**IW];
  logic [IW-1:0] fill_len;
  logic [IW-1:0] unsent_end;
  logic [IW-1:0] word_pos;
  logic [IW-1:0] word_end;
  logic          in_word;
  logic          pulling;
  res_item_t     expected_bytes [$];
  int            results_seen;

  task automatic report_mismatch(input string what);
    $display("[%0t] result %0d: %s", $realtime, results_seen, what);
    fail_count++;
  endtask

  function automatic void store_byte(input logic [7:0] b);
    // a push after pulling has begun starts a new sentence
    if (pulling) begin
      pulling = 1'b0;
      fill_len = '0;
      unsent_end = '0;
      in_word = 1'b0;
    end
    if (fill_len < MAX_LEN) begin
      sentence_mem[fill_len] = b;
      fill_len++;
    end
  endfunction

  function automatic logic [7:0] word_next();
    logic [7:0] b;
    b = sentence_mem[word_pos];
    word_pos++;
    if (word_pos >= word_end) begin
      in_word = 1'b0;
    end
    return b;
  endfunction

  function automatic res_item_t next_pull();
    res_item_t     r;
    logic [IW-1:0] s;
    logic [7:0]    b;
    r = '0;
    if (!pulling) begin
      pulling = 1'b1;
      unsent_end = fill_len;
      in_word = 1'b0;
      word_pos = '0;
      word_end = '0;
    end
    if (in_word) begin
      b = word_next();
    end else if (unsent_end == 0) begin
      return r;
    end else if (sentence_mem[unsent_end - IW'(1)] == SPACE_BYTE) begin
      b = SPACE_BYTE;
      unsent_end--;
    end else begin
      // scan back to the start of the last word still unsent
      s = unsent_end - IW'(1);
      while (s > 0 && sentence_mem[s - IW'(1)] != SPACE_BYTE) begin
        s--;
      end
      word_end = unsent_end;
      word_pos = s;
      unsent_end = s;
      in_word = 1'b1;
      b = word_next();
    end
    r.out_byte = b;
    r.out_valid = 1'b1;
    r.out_last = !in_word && unsent_end == 0;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    res_item_t want;
    if (rst) begin
      fill_len = '0;
      unsent_end = '0;
      word_pos = '0;
      word_end = '0;
      in_word = 1'b0;
      pulling = 1'b0;
      fail_count = 0;
      results_seen = 0;
      expected_bytes.delete();
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected beat: byte %02h valid %0b last %0b",
                                    res_item.out_byte, res_item.out_valid,
                                    res_item.out_last));
        end else begin
          want = expected_bytes.pop_front();
          if (res_item.out_byte !== want.out_byte) begin
            report_mismatch($sformatf("out_byte %02h, want %02h",
                                      res_item.out_byte, want.out_byte));
          end
          if (res_item.out_valid !== want.out_valid) begin
            report_mismatch($sformatf("out_valid %0b, want %0b",
                                      res_item.out_valid, want.out_valid));
          end
          if (res_item.out_last !== want.out_last) begin
            report_mismatch($sformatf("out_last %0b, want %0b",
                                      res_item.out_last, want.out_last));
          end
        end
        results_seen++;
      end
      if (in_valid && !in_stall) begin
        if (in_item.kind == KIND_PUSH) begin
          store_byte(in_item.data_byte);
        end else begin
          expected_bytes.push_back(next_pull());
        end
      end
    end
    outstanding <= expected_bytes.size();
  end

endmodule

// ===== bench/sentence_word_order_reverser_tb.sv =====
// ----------------------------------------------------------------------------
// sentence_word_order_reverser_tb
// drives push and pull beats into the reverser with random gaps on both
// channels; a directed opener covers empty pulls, edge bytes, space runs and
// restart after pulling, then random sentences
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sentence_word_order_reverser_tb;
  import swr_pkg::*;

  localparam int STORE_LEN = MAX_LEN_DEF;
  localparam int RANDOM_BEATS = 1000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      res_valid;
  logic      res_stall;
  res_item_t res_item;
  int        fail_count;
  int        outstanding;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  int        beats_sent = 0;

  sentence_word_order_reverser #(
    .MAX_LEN(STORE_LEN)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_item (res_item)
  );

  swr_reorder_checker #(
    .MAX_LEN(STORE_LEN)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("sentence_word_order_reverser test failed");
    $finish;
  end

  always @(posedge clk) begin
    res_stall <= $urandom_range(0, 99) < rx_idle_pct;
  end

  task automatic send_beat(input logic kind, input logic [7:0] data);
    in_item_t beat;
    beat.kind = kind;
    beat.data_byte = data;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= beat;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  task automatic pull_bytes(input int n);
    for (int i = 0; i < n; i++) begin
      send_beat(KIND_PULL, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic random_sentence();
    int         len;
    int         mode;
    int         r;
    logic [7:0] b;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 12);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        b = SPACE_BYTE;
      end else if (r < 35) begin
        b = 8'h00;
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      send_beat(KIND_PUSH, b);
    end
    mode = $urandom_range(0, 9);
    if (mode < 7) begin
      pull_bytes(len + $urandom_range(0, 2));
    end else if (mode < 9) begin
      // partial pull, the next push restarts
      pull_bytes($urandom_range(0, len));
    end else begin
      for (int i = 0; i < $urandom_range(1, 8); i++) begin
        send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    int goal;
    in_valid <= 1'b0;
    in_item <= '0;
    rst <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty store, then edge bytes with leading, inner and trailing spaces
    pull_bytes(1);
    send_beat(KIND_PUSH, SPACE_BYTE);
    send_beat(KIND_PUSH, 8'h61);
    send_beat(KIND_PUSH, 8'h62);
    send_beat(KIND_PUSH, 8'h00);
    send_beat(KIND_PUSH, SPACE_BYTE);
    send_beat(KIND_PUSH, SPACE_BYTE);
    send_beat(KIND_PUSH, 8'hff);
    send_beat(KIND_PUSH, 8'h63);
    send_beat(KIND_PUSH, SPACE_BYTE);
    pull_bytes(11);
    send_beat(KIND_PUSH, 8'h71);
    pull_bytes(1);
    send_beat(KIND_PUSH, 8'h72);
    pull_bytes(2);
    drain_results();

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 68 : 0;
      rx_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 34 : 0;
      goal = beats_sent + RANDOM_BEATS / 3;
      while (beats_sent < goal) begin
        random_sentence();
        if ($urandom_range(0, 19) == 0) begin
          drain_results();
        end
      end
      drain_results();
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("sentence_word_order_reverser test passed");
    end else begin
      $display("sentence_word_order_reverser test failed");
    end
    $finish;
  end

endmodule
